[rtl/mhs_pkg.sv]
package mhs_pkg;

	localparam int unsigned VALUE_W      = 31;
	localparam int unsigned NUM_BUCKETS  = 13;
	localparam int unsigned BUCKET_DEPTH = 8;

	localparam int unsigned BUCKET_W = $clog2(NUM_BUCKETS);
	localparam int unsigned SLOT_W   = (BUCKET_DEPTH > 1) ? $clog2(BUCKET_DEPTH) : 1;
	localparam int unsigned FILL_W   = $clog2(BUCKET_DEPTH + 1);

	// bucket = value - N * floor(value * RECIP / 2^SHIFT), exact for every value
	localparam int unsigned SHIFT    = VALUE_W + $clog2(NUM_BUCKETS);
	localparam int unsigned RECIP_W  = 32;
	localparam logic [63:0] RECIP_FULL =
		((64'd1 << SHIFT) + 64'(NUM_BUCKETS) - 64'd1) / 64'(NUM_BUCKETS);
	localparam logic [RECIP_W-1:0] RECIP = RECIP_FULL[RECIP_W-1:0];
	localparam int unsigned PROD_W   = VALUE_W + RECIP_W;
	localparam int unsigned QUOT_W   = PROD_W - SHIFT;

	localparam logic KIND_INSERT = 1'b0;
	localparam logic KIND_SEARCH = 1'b1;

	typedef struct packed {
		logic capture;
		logic reduce;
		logic read;
		logic commit;
	} ctl_cmd_t;

endpackage

[rtl/mhs_ctrl.sv]
module mhs_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic               out_stall,
	output logic               out_valid,
	output mhs_pkg::ctl_cmd_t  cmd
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_MOD  = 2'd1;
	localparam logic [1:0] ST_READ = 2'd2;
	localparam logic [1:0] ST_DONE = 2'd3;

	logic [1:0] state_q;
	logic [1:0] state_d;
	logic       out_valid_q;
	logic       out_free;

	assign in_stall  = (state_q != ST_IDLE);
	assign out_valid = out_valid_q;
	assign out_free  = !out_valid_q || !out_stall;

	assign cmd.capture = in_valid && !in_stall;
	assign cmd.reduce  = (state_q == ST_MOD);
	assign cmd.read    = (state_q == ST_READ);
	assign cmd.commit  = (state_q == ST_DONE) && out_free;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) state_d = ST_MOD;
			end
			ST_MOD:  state_d = ST_READ;
			ST_READ: state_d = ST_DONE;
			ST_DONE: begin
				// hold until the previous result has been transferred
				if (out_free) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.commit) out_valid_q <= 1'b1;
			else if (!out_stall) out_valid_q <= 1'b0;
		end
	end

endmodule

[rtl/mhs_dp.sv]
module mhs_dp (
	input  logic                          clk,
	input  logic                          arst_n,
	input  mhs_pkg::ctl_cmd_t             cmd,
	input  logic                          kind,
	input  logic [mhs_pkg::VALUE_W-1:0]   value,
	output logic                          found,
	output logic                          status
);

	logic                                kind_q;
	logic [mhs_pkg::VALUE_W-1:0]         value_q;
	logic [mhs_pkg::PROD_W-1:0]          prod_s1;
	logic [mhs_pkg::QUOT_W-1:0]          quot;
	logic [mhs_pkg::VALUE_W-1:0]         rem;
	logic [mhs_pkg::BUCKET_W-1:0]        bucket_q;
	logic [mhs_pkg::FILL_W-1:0]          fill_q [mhs_pkg::NUM_BUCKETS];
	logic [mhs_pkg::FILL_W-1:0]          cur_fill_q;
	logic [mhs_pkg::BUCKET_DEPTH-1:0][mhs_pkg::VALUE_W-1:0] mem [mhs_pkg::NUM_BUCKETS];
	logic [mhs_pkg::BUCKET_DEPTH-1:0][mhs_pkg::VALUE_W-1:0] row_q;
	logic                                full;
	logic                                hit;
	logic                                do_write;
	logic                                found_q;
	logic                                status_q;

	assign found  = found_q;
	assign status = status_q;

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			kind_q  <= kind;
			value_q <= value;
			prod_s1 <= mhs_pkg::PROD_W'(value) * mhs_pkg::PROD_W'(mhs_pkg::RECIP);
		end
	end

	assign quot = prod_s1[mhs_pkg::PROD_W-1:mhs_pkg::SHIFT];
	assign rem  = value_q - mhs_pkg::VALUE_W'(mhs_pkg::VALUE_W'(quot) *
		mhs_pkg::VALUE_W'(mhs_pkg::NUM_BUCKETS));

	always_ff @(posedge clk) begin
		if (cmd.reduce) bucket_q <= rem[mhs_pkg::BUCKET_W-1:0];
	end

	assign full = (cur_fill_q == mhs_pkg::FILL_W'(mhs_pkg::BUCKET_DEPTH));
	assign do_write = cmd.commit && (kind_q == mhs_pkg::KIND_INSERT) && !full;

	always_comb begin
		hit = 1'b0;
		for (int i = 0; i < int'(mhs_pkg::BUCKET_DEPTH); i++) begin
			if ((mhs_pkg::FILL_W'(i) < cur_fill_q) && (row_q[i] == value_q)) hit = 1'b1;
		end
	end

	// bucket row store: at most one entry written and one row read per cycle
	always_ff @(posedge clk) begin
		if (do_write) mem[bucket_q][cur_fill_q[mhs_pkg::SLOT_W-1:0]] <= value_q;
		if (cmd.read) row_q <= mem[bucket_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int b = 0; b < int'(mhs_pkg::NUM_BUCKETS); b++) fill_q[b] <= '0;
		end else begin
			if (do_write) fill_q[bucket_q] <= cur_fill_q + mhs_pkg::FILL_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.read) cur_fill_q <= fill_q[bucket_q];
		if (cmd.commit) begin
			if (kind_q == mhs_pkg::KIND_SEARCH) begin
				found_q  <= hit;
				status_q <= 1'b0;
			end else begin
				found_q  <= 1'b0;
				status_q <= full;
			end
		end
	end

endmodule

[rtl/modulo_hash_set_insert_search_top.sv]
// An accepted item passes the controller states MOD, READ and DONE; out_valid is set
// from the DONE commit, which waits until the previous result has been transferred.
// Items are handled one at a time (reciprocal multiply, bucket reduce,
// row read, compare and write back); a stalled output holds the last step.
// Reset: arst_n clears the controller, the output valid and all bucket fill
// counts at once; stored entries are not cleared and need no sweep.
module modulo_hash_set_insert_search_top (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic                         kind,
	input  logic [mhs_pkg::VALUE_W-1:0]  value,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic                         found,
	output logic                         status
);

	mhs_pkg::ctl_cmd_t cmd;

	mhs_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_stall (out_stall),
		.out_valid (out_valid),
		.cmd       (cmd)
	);

	mhs_dp u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.kind   (kind),
		.value  (value),
		.found  (found),
		.status (status)
	);

endmodule

[rtl/mhs_check.sv]
module mhs_check (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         in_valid,
	input logic                         in_stall,
	input logic                         out_valid,
	input logic                         out_stall,
	input logic                         found,
	input logic                         status
);

	logic in_xfer;

	assign in_xfer = in_valid && !in_stall;

	// one item at a time: busy straight after a transfer
	a_busy_after_xfer: assert property (@(posedge clk) disable iff (!arst_n)
		in_xfer |=> in_stall)
		else $error("input not stalled after transfer");

	// each rise of out_valid must go back to a matching earlier input transfer
	a_result_latency: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_xfer, 4))
		else $error("result without matching input transfer");

	a_found_excl: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(found && status))
		else $error("found and status both set");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(found) && $stable(status))
		else $error("stalled result changed");

endmodule

bind modulo_hash_set_insert_search_top mhs_check u_mhs_check (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_stall  (in_stall),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.found     (found),
	.status    (status)
);
